// ===== src/tksi_pkg.sv =====
// Shared types and constants for the sorted top-K insertion block.
// Used by top_k_sorted_insert_top; depends on nothing else.
package tksi_pkg;

   // Sizing of the lists.
   localparam int MAX_ENTRIES = 20;
   localparam int NUM_BOARDS  = 2;
   localparam int VALUE_BITS  = 32;

   // Derived widths.
   localparam int DEPTH   = NUM_BOARDS * MAX_ENTRIES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int BOARD_W = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
   localparam int CMP_W   = (CNT_W > 5) ? CNT_W : 5;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef logic [VALUE_BITS-1:0] value_type;

   // Input word.
   typedef struct packed {
      logic        operation;
      logic        board;
      logic [31:0] score_value;
      logic [4:0]  entry_index;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [4:0]  rank;
      logic [31:0] entry_value;
      logic [4:0]  entry_count;
      logic [31:0] best_value;
      logic        new_best;
   } rsp_type;

   // Flat memory address of one list entry: boards are laid out one after another.
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [BOARD_W-1:0] b,
                                                    input logic [IDX_W-1:0]   i);
      return ADDR_W'(ADDR_W'(b) * ADDR_W'(MAX_ENTRIES)) + ADDR_W'(i);
   endfunction

endpackage

// ===== src/top_k_sorted_insert_top.sv =====
// Top level of the sorted top-K insertion block: control sequencer, per-board
// counts and personal bests, and the list store. Depends on tksi_pkg and tksi_ram.
//
// Keeps one descending list of up to MAX_ENTRIES values per board in a single
// RAM, plus an entry count and a personal best per board in flip-flops. An insert
// walks its list from the last held entry upward, one entry per cycle, moving
// each entry that is not greater than the new value down one place and stopping
// at the first greater one; the value then goes into the freed slot and its
// 1-based rank is returned (0 when it falls off a full list). The walk is paced by
// the one read and one write per cycle of the RAM. A read fetches its entry from the
// RAM, builds the result in ST_READ and hands it on from ST_REPLY. One word is in
// work at a time; a new word is accepted while the previous result still waits in
// the output register. Entries past the count are never read, so the store needs
// no clearing pass after reset.
module top_k_sorted_insert_top
   import tksi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_PUT_TOP,
      ST_REPLY
   } state_type;

   state_type          state_ff;
   logic [BOARD_W-1:0] board_ff;
   value_type          value_ff;
   logic [IDX_W-1:0]   ptr_ff;
   logic               hit_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic [CNT_W-1:0]   count_ff [NUM_BOARDS];
   value_type          best_ff  [NUM_BOARDS];

   // RAM ports.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   value_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   value_type         rd_data;

   // Decode of the incoming word.
   logic               accept;
   logic [BOARD_W-1:0] b_in;
   logic               board_ok;
   value_type          v_in;
   logic [CNT_W-1:0]   cnt_in;
   logic               hit_in;
   logic               raise_best;

   // Scan and finish terms.
   logic             scan_gt;
   logic             ptr_last;
   logic             fin_ranked;
   logic [CNT_W-1:0] fin_rank;
   logic [CNT_W-1:0] cnt_cur;
   logic [CNT_W-1:0] cnt_new;
   logic             rsp_load;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign b_in       = BOARD_W'(req_data.board);
   assign board_ok   = (32'(req_data.board) < 32'(NUM_BOARDS));
   assign v_in       = VALUE_BITS'(req_data.score_value);
   assign cnt_in     = board_ok ? count_ff[b_in] : '0;
   assign hit_in     = CMP_W'(req_data.entry_index) < CMP_W'(cnt_in);
   assign raise_best = v_in > best_ff[b_in];

   assign scan_gt  = rd_data > value_ff;
   assign ptr_last = (ptr_ff == IDX_W'(MAX_ENTRIES - 1));
   assign cnt_cur  = count_ff[board_ff];

   // The finished word moves into the output register when that is free.
   assign rsp_load = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_ready);

   // Rank and new count when the insert completes.
   always_comb begin
      if (state_ff == ST_PUT_TOP) begin
         fin_ranked = 1'b1;
         fin_rank   = CNT_W'(1);
      end else begin
         fin_ranked = !ptr_last;
         fin_rank   = CNT_W'(ptr_ff) + CNT_W'(2);
      end
      if (fin_ranked && (cnt_cur < CNT_W'(MAX_ENTRIES))) begin
         cnt_new = cnt_cur + CNT_W'(1);
      end else begin
         cnt_new = cnt_cur;
      end
   end

   // RAM access: one read and one write per cycle at different entries.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = entry_addr(board_ff, ptr_ff + IDX_W'(1));
      wr_data = rd_data;
      rd_en   = 1'b0;
      rd_addr = entry_addr(board_ff, ptr_ff - IDX_W'(1));
      case (state_ff)
         ST_IDLE: begin
            if (req_data.operation == OP_READ) begin
               rd_addr = entry_addr(b_in, IDX_W'(req_data.entry_index));
               rd_en   = accept && board_ok && hit_in;
            end else begin
               rd_addr = entry_addr(b_in, IDX_W'(cnt_in - CNT_W'(1)));
               rd_en   = accept && board_ok && (cnt_in != '0);
            end
         end
         ST_SCAN: begin
            // Move the entry down one place, or store the value below a greater one.
            wr_en   = !ptr_last;
            wr_data = scan_gt ? value_ff : rd_data;
            rd_en   = !scan_gt && (ptr_ff != '0);
         end
         ST_PUT_TOP: begin
            wr_en   = 1'b1;
            wr_addr = entry_addr(board_ff, '0);
            wr_data = value_ff;
         end
         default: begin
         end
      endcase
   end

   tksi_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer, per-board state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BOARDS; b++) begin
            count_ff[b] <= '0;
            best_ff[b]  <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  board_ff           <= b_in;
                  value_ff           <= v_in;
                  hit_ff             <= hit_in;
                  res_ff.rank        <= '0;
                  res_ff.entry_value <= '0;
                  res_ff.entry_count <= '0;
                  res_ff.best_value  <= '0;
                  res_ff.new_best    <= board_ok && (req_data.operation == OP_INSERT)
                                        && raise_best;
                  if (!board_ok) begin
                     state_ff <= ST_REPLY;
                  end else if (req_data.operation == OP_READ) begin
                     ptr_ff   <= IDX_W'(req_data.entry_index);
                     state_ff <= ST_READ;
                  end else begin
                     // The personal best moves at once; only this board is touched.
                     if (raise_best) begin
                        best_ff[b_in] <= v_in;
                     end
                     ptr_ff   <= IDX_W'(cnt_in - CNT_W'(1));
                     state_ff <= (cnt_in == '0) ? ST_PUT_TOP : ST_SCAN;
                  end
               end
            end
            ST_READ: begin
               res_ff.rank        <= hit_ff ? 5'(CNT_W'(ptr_ff) + CNT_W'(1)) : 5'd0;
               res_ff.entry_value <= hit_ff ? 32'(rd_data) : 32'd0;
               res_ff.entry_count <= 5'(cnt_cur);
               res_ff.best_value  <= 32'(best_ff[board_ff]);
               state_ff           <= ST_REPLY;
            end
            ST_SCAN, ST_PUT_TOP: begin
               if ((state_ff == ST_PUT_TOP) || scan_gt) begin
                  count_ff[board_ff] <= cnt_new;
                  res_ff.rank        <= fin_ranked ? 5'(fin_rank) : 5'd0;
                  res_ff.entry_value <= 32'(value_ff);
                  res_ff.entry_count <= 5'(cnt_new);
                  res_ff.best_value  <= 32'(best_ff[board_ff]);
                  state_ff           <= ST_REPLY;
               end else if (ptr_ff == '0) begin
                  // Every held entry was moved down: the value goes on top.
                  state_ff <= ST_PUT_TOP;
               end else begin
                  ptr_ff <= ptr_ff - IDX_W'(1);
               end
            end
            ST_REPLY: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A delivered rank never lies below the end of its list.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.rank <= rsp_data.entry_count))
      else $error("rank beyond entry count");

   // A raised personal best is the inserted value itself.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.new_best) |-> (rsp_data.entry_value == rsp_data.best_value))
      else $error("new best differs from inserted value");

   // Only one word is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while busy");

   // The scan pointer stays inside the list.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(ptr_ff) < count_ff[board_ff]))
      else $error("scan pointer past list end");

endmodule

// ===== src/tksi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tksi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
